@@ src/sfd_pkg.sv @@
`default_nettype none

package sfd_pkg;

	localparam int unsigned BUFFER_DEPTH = 32;
	localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned POS_W = 5;

	localparam logic [7:0] HDR_FIRST  = 8'hFE;
	localparam logic [7:0] HDR_SECOND = 8'hEF;
	localparam logic [8:0] SUM_WRAP   = 9'd255;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_HEADER  = 2'd1,
		ST_BAD_LENGTH = 2'd2,
		ST_BAD_SUM    = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    hunt_inc;
		logic    hunt_clr;
		logic    len_load;
		logic    pay_wr;
		logic    rd_start;
		logic    rd_issue;
		logic    emit_byte;
		logic    emit_err;
		status_t err_code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hdr_first;
		logic hdr_second;
		logic hunt_limit;
		logic len_bad;
		logic fill_done;
		logic sum_match;
		logic rd_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ src/sfd_dp.sv @@
`default_nettype none

module sfd_dp (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   rx_byte,
	input  wire sfd_pkg::cmd_t cmd,
	output sfd_pkg::sts_t     sts,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tlast,
	output logic [1:0]        m_tuser
);
	import sfd_pkg::*;

	logic [CNT_W-1:0] hunt_q;
	logic [CNT_W-1:0] frame_len_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rd_q;
	logic [7:0]       sum_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       store_q [BUFFER_DEPTH];

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;
	logic [1:0]       out_status_q;

	logic [8:0]       sum_ext;
	logic [7:0]       sum_next;

	always_comb begin
		sum_ext = {1'b0, sum_q} + {1'b0, rx_byte};
		if (sum_ext > SUM_WRAP) begin
			sum_ext = sum_ext - SUM_WRAP;
		end
		sum_next = sum_ext[7:0];
	end

	assign sts.hdr_first  = (rx_byte == HDR_FIRST);
	assign sts.hdr_second = (rx_byte == HDR_SECOND);
	assign sts.hunt_limit = ({1'b0, hunt_q} + 1'b1) >= (CNT_W + 1)'(BUFFER_DEPTH);
	assign sts.len_bad    = (rx_byte == 8'd0) || ({1'b0, rx_byte} > 9'(BUFFER_DEPTH));
	assign sts.fill_done  = ({1'b0, fill_q} + 1'b1) >= {1'b0, frame_len_q};
	assign sts.sum_match  = (rx_byte == sum_q);
	assign sts.rd_last    = ({1'b0, rd_q} + 1'b1) == {1'b0, frame_len_q};
	assign sts.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q      <= '0;
			frame_len_q <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			rd_q        <= '0;
		end else begin
			if (cmd.hunt_clr) begin
				hunt_q <= '0;
			end else if (cmd.hunt_inc) begin
				hunt_q <= hunt_q + 1'b1;
			end
			if (cmd.len_load) begin
				frame_len_q <= rx_byte[CNT_W-1:0];
				fill_q      <= '0;
				sum_q       <= '0;
			end else if (cmd.pay_wr) begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_next;
			end
			if (cmd.rd_start) begin
				rd_q <= '0;
			end else if (cmd.emit_byte) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// Payload buffer: written while the frame arrives, read back one entry at a time.
	always_ff @(posedge clk) begin
		if (cmd.pay_wr) begin
			store_q[fill_q[IDX_W-1:0]] <= rx_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= store_q[rd_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_byte || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_byte_q   <= '0;
			out_pos_q    <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.err_code;
		end else if (cmd.emit_byte) begin
			out_byte_q   <= rd_data_q;
			out_pos_q    <= POS_W'(rd_q);
			out_last_q   <= sts.rd_last;
			out_status_q <= ST_OK;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - 8 - POS_W){1'b0}}, out_pos_q, out_byte_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pay_wr |-> (fill_q < frame_len_q))
		else $error("payload write beyond the announced length");

	a_read_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_byte |-> (rd_q < frame_len_q))
		else $error("replay beyond the stored payload");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> (m_tvalid && m_tlast && (m_tdata[7:0] == 8'd0)))
		else $error("error result not marked as a lone last transfer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_byte || cmd.emit_err) |-> (!out_valid_q || m_tready))
		else $error("output register loaded while its result is still pending");

endmodule

`default_nettype wire

@@ src/sfd_ctrl.sv @@
`default_nettype none

module sfd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire sfd_pkg::sts_t sts,
	output sfd_pkg::cmd_t      cmd
);
	import sfd_pkg::*;

	typedef enum logic [6:0] {
		S_HUNT      = 7'b0000001,
		S_HUNT_SEEN = 7'b0000010,
		S_LENGTH    = 7'b0000100,
		S_PAYLOAD   = 7'b0001000,
		S_CHECK     = 7'b0010000,
		S_READ      = 7'b0100000,
		S_EMIT      = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_phase;
	logic   take;

	assign in_phase = (state_q == S_HUNT) || (state_q == S_HUNT_SEEN) ||
		(state_q == S_LENGTH) || (state_q == S_PAYLOAD) || (state_q == S_CHECK);
	assign s_tready = in_phase && sts.out_free;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.err_code = ST_OK;
		case (state_q)
			S_HUNT, S_HUNT_SEEN: begin
				if (take) begin
					if (sts.hdr_second && (state_q == S_HUNT_SEEN)) begin
						cmd.hunt_clr = 1'b1;
						state_d      = S_LENGTH;
					end else if (sts.hunt_limit) begin
						cmd.hunt_clr = 1'b1;
						cmd.emit_err = 1'b1;
						cmd.err_code = ST_NO_HEADER;
						state_d      = S_HUNT;
					end else begin
						cmd.hunt_inc = 1'b1;
						state_d      = sts.hdr_first ? S_HUNT_SEEN : S_HUNT;
					end
				end
			end
			S_LENGTH: begin
				if (take) begin
					if (sts.len_bad) begin
						cmd.emit_err = 1'b1;
						cmd.err_code = ST_BAD_LENGTH;
						state_d      = S_HUNT;
					end else begin
						cmd.len_load = 1'b1;
						state_d      = S_PAYLOAD;
					end
				end
			end
			S_PAYLOAD: begin
				if (take) begin
					cmd.pay_wr = 1'b1;
					if (sts.fill_done) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (take) begin
					if (!sts.sum_match) begin
						cmd.emit_err = 1'b1;
						cmd.err_code = ST_BAD_SUM;
						state_d      = S_HUNT;
					end else begin
						cmd.rd_start = 1'b1;
						state_d      = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					state_d       = sts.rd_last ? S_HUNT : S_READ;
				end
			end
			default: begin
				cmd.hunt_clr = 1'b1;
				state_d      = S_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ src/serial_frame_deframer.sv @@
`default_nettype none

// Serial frame deframer. Each input transfer carries one received byte. The block
// hunts for the header FE EF, takes a length byte of 1 to BUFFER_DEPTH (32), stores
// that many payload bytes and compares the next byte with a running sum of the
// payload, where 255 is subtracted whenever the sum passes 255. A good frame is
// replayed as one output transfer per payload byte, with tlast on the final byte.
// A hunt that runs BUFFER_DEPTH bytes without a header, a bad length or a checksum
// mismatch each give a single output transfer with tlast set, a zero payload and
// the error code in tuser, after which hunting starts over. Header, length and
// payload bytes are taken one per cycle whenever the output register is free. The
// replay passes each payload byte through the registered read of the payload
// buffer and then the load of the output register, which waits while it is busy,
// and no input byte is taken until the replay of a frame has finished.
module serial_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] payload_byte, [12:8] byte_position
	output logic             m_tlast,   // last_of_run
	output logic [1:0]       m_tuser    // [1:0] status
);
	import sfd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences the frame phases and the replay.
	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the counters, the checksum, the payload buffer and the
	// output register.
	sfd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;
	import sfd_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned STALL_LIMIT  = 5000;
	localparam int unsigned DRAIN_CYCLES = 4 * BUFFER_DEPTH + 16;
	localparam int unsigned RANDOM_BYTES = 50;

	typedef enum logic [2:0] {
		P_SEEK,
		P_SEEK_FE,
		P_LEN,
		P_BODY,
		P_SUM
	} parse_phase_t;

	typedef struct {
		status_t    status;
		logic [7:0] data;
		logic [4:0] pos;
		logic       last;
	} deframed_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tready = 1'b0;
	wire logic        s_tready;
	wire logic        m_tvalid;
	wire logic [15:0] m_tdata;
	wire logic        m_tlast;
	wire logic [1:0]  m_tuser;

	serial_frame_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Parser state mirrored from the block.
	parse_phase_t rx_phase   = P_SEEK;
	int unsigned  seek_count = 0;
	int unsigned  frame_len  = 0;
	int unsigned  fill_pos   = 0;
	logic [8:0]   body_sum   = 9'd0;
	logic [7:0]   body_store [BUFFER_DEPTH];

	deframed_t   expected_q [$];
	int unsigned mismatch_count = 0;
	int unsigned bytes_sent     = 0;
	int unsigned burst_left     = 0;
	bit          hold_req       = 1'b0;

	function automatic logic [8:0] fold_sum(input logic [8:0] acc, input logic [7:0] b);
		logic [8:0] t;
		t = acc + {1'b0, b};
		if (t > SUM_WRAP) begin
			t = t - SUM_WRAP;
		end
		return t;
	endfunction

	// Any byte except the first header byte, so that noise cannot open a header.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == HDR_FIRST);
		return b;
	endfunction

	task automatic expect_error(input status_t code);
		deframed_t r;
		r.status = code;
		r.data   = 8'h00;
		r.pos    = 5'd0;
		r.last   = 1'b1;
		expected_q.push_back(r);
		rx_phase   = P_SEEK;
		seek_count = 0;
	endtask

	task automatic predict_deframe(input logic [7:0] b);
		deframed_t r;
		case (rx_phase)
			P_SEEK, P_SEEK_FE: begin
				seek_count++;
				if (b == HDR_SECOND && rx_phase == P_SEEK_FE) begin
					rx_phase   = P_LEN;
					seek_count = 0;
				end else begin
					rx_phase = (b == HDR_FIRST) ? P_SEEK_FE : P_SEEK;
					if (seek_count >= BUFFER_DEPTH) begin
						expect_error(ST_NO_HEADER);
					end
				end
			end
			P_LEN: begin
				if (b == 8'd0 || b > BUFFER_DEPTH) begin
					expect_error(ST_BAD_LENGTH);
				end else begin
					frame_len = b;
					fill_pos  = 0;
					body_sum  = 9'd0;
					rx_phase  = P_BODY;
				end
			end
			P_BODY: begin
				body_store[fill_pos] = b;
				body_sum = fold_sum(body_sum, b);
				fill_pos++;
				if (fill_pos >= frame_len) begin
					rx_phase = P_SUM;
				end
			end
			default: begin
				if ({1'b0, b} != body_sum) begin
					expect_error(ST_BAD_SUM);
				end else begin
					for (int i = 0; i < int'(frame_len); i++) begin
						r.status = ST_OK;
						r.data   = body_store[i];
						r.pos    = 5'(i);
						r.last   = (i == int'(frame_len) - 1);
						expected_q.push_back(r);
					end
					rx_phase   = P_SEEK;
					seek_count = 0;
				end
			end
		endcase
	endtask

	// Entered just after a rising edge; returns at the rising edge of acceptance.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		predict_deframe(b);
		bytes_sent++;
	endtask

	task automatic send_header();
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
	endtask

	// Length, payload and checksum; the checksum is spoiled on request.
	task automatic send_body(input int unsigned len, input bit bad_sum);
		logic [8:0] acc;
		logic [7:0] b;
		acc = 9'd0;
		send_byte(8'(len));
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b);
			acc = fold_sum(acc, b);
		end
		b = acc[7:0];
		if (bad_sum) begin
			b = b ^ 8'($urandom_range(1, 255));
		end
		send_byte(b);
	endtask

	task automatic send_frame(input int unsigned len, input bit bad_sum);
		send_header();
		send_body(len, bad_sum);
	endtask

	function automatic int unsigned pick_length();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7) begin
			return $urandom_range(1, 6);
		end else if (roll < 9) begin
			return $urandom_range(7, 16);
		end
		return $urandom_range(17, BUFFER_DEPTH);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Receiver: ready pattern switches between randomly chosen modes, and a
	// requested hold keeps it low for a long stretch.
	initial begin : receiver
		int unsigned mode_left;
		int unsigned mode;
		int unsigned tick;
		mode_left = 0;
		mode      = 0;
		tick      = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (tick % 3 != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		deframed_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer status %0d data %02h",
					m_tuser, m_tdata[7:0]));
			end else begin
				want = expected_q.pop_front();
				if (m_tuser != want.status) begin
					report_mismatch($sformatf("status got %0d want %0d",
						m_tuser, want.status));
				end
				if (m_tdata[7:0] != want.data) begin
					report_mismatch($sformatf("payload got %02h want %02h",
						m_tdata[7:0], want.data));
				end
				if (m_tdata[12:8] != want.pos) begin
					report_mismatch($sformatf("position got %0d want %0d",
						m_tdata[12:8], want.pos));
				end
				if (m_tlast != want.last) begin
					report_mismatch($sformatf("tlast got %0b want %0b",
						m_tlast, want.last));
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		int unsigned quiet_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Short frames, repeated first header byte, bad lengths and a bad checksum.
	task automatic test_directed();
		send_header();
		send_byte(8'd1);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(HDR_FIRST);
		send_header();
		send_byte(8'd2);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_header();
		send_byte(8'd0);
		send_header();
		send_byte(8'(BUFFER_DEPTH + 1));
		send_header();
		send_byte(8'hFF);
		send_header();
		send_byte(8'd1);
		send_byte(8'h05);
		send_byte(8'h06);
	endtask

	// Full-length frame and the edges of the header hunt limit.
	task automatic test_full_length_and_hunt();
		send_frame(BUFFER_DEPTH, 1'b0);
		repeat (BUFFER_DEPTH) send_byte(plain_byte());
		repeat (BUFFER_DEPTH - 2) send_byte(plain_byte());
		send_header();
		send_body(1, 1'b0);
		// The first header byte on the limit byte is dropped with the error.
		repeat (BUFFER_DEPTH - 1) send_byte(plain_byte());
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_frame(2, 1'b0);
	endtask

	// Output held off for a long stretch while frames keep coming.
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (3) send_frame(8, 1'b0);
	endtask

	task automatic test_random_frames();
		int unsigned start;
		int unsigned kind;
		int unsigned len;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3, 4, 5: begin
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 3)) send_byte(plain_byte());
					end
					send_frame(pick_length(), 1'b0);
				end
				6: begin
					send_header();
					if ($urandom_range(0, 1) == 0) begin
						send_byte(8'd0);
					end else begin
						send_byte(8'($urandom_range(BUFFER_DEPTH + 1, 255)));
					end
				end
				7: send_frame(pick_length(), 1'b1);
				8: begin
					// Frame cut short: following bytes land in its payload.
					len = pick_length();
					send_header();
					send_byte(8'(len));
					repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_length_and_hunt();
		test_backpressure();
		test_random_frames();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
